>>> rtl/mpct_pkg.sv
// shared types, field widths and header decode helpers for the mouse cursor tracker
package mpct_pkg;

    localparam int RX_W      = 8;
    localparam int OUT_W     = 12;
    localparam int RES_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int DELTA_W   = 11;

    localparam logic [RES_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [RES_W-1:0] HEIGHT_RESET = 13'd480;

    // header byte bit positions
    localparam int HDR_SYNC  = 3;
    localparam int HDR_XSIGN = 4;
    localparam int HDR_YSIGN = 5;
    localparam int HDR_XOVF  = 6;
    localparam int HDR_YOVF  = 7;

    localparam logic [DELTA_W-1:0] OVF_EXTRA = 11'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH  = 2'd0,
        REG_SCREEN_HEIGHT = 2'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        BYTE_HDR = 2'd0,
        BYTE_X   = 2'd1,
        BYTE_Y   = 2'd2
    } t_byte_idx;

    // nine-bit two's complement delta, widened by 255 on overflow
    function automatic logic signed [DELTA_W-1:0] axis_delta(
        input logic [RX_W-1:0] data,
        input logic            neg,
        input logic            ovf
    );
        logic signed [DELTA_W-1:0] d;
        d = $signed({{(DELTA_W-RX_W-1){neg}}, neg, data});
        if (ovf) begin
            if (neg) begin
                d = d - $signed(OVF_EXTRA);
            end else begin
                d = d + $signed(OVF_EXTRA);
            end
        end
        return d;
    endfunction

endpackage

>>> rtl/mouse_packet_cursor_tracker_core.sv
// top level: three-byte mouse packet decoder with clamped cursor position output
//
// usage:
//   slave stream (i_s_*) takes one received mouse byte per transfer. a packet is
//   a header byte (bit 3 set, else the byte is dropped while hunting for a header),
//   an x delta byte and a y delta byte. the third byte moves the cursor by +x and
//   -y (plus 255 in the delta's direction on overflow), clamps each axis to
//   0..min(res-1, CMAX) and produces one transfer on the master stream (o_m_*).
//   config channel (i_cfg_*) writes screen_width (index 0) and screen_height
//   (index 1); always ready, so the user must use it only while the block is idle.
// timing:
//   one byte per cycle while the output is not stalled. the position result is
//   registered and appears on o_m_tdata in the cycle after the third byte is
//   taken; the position update and clamp sit in a single combinational step
//   between the stream input and the position and output registers.
// reset:
//   synchronous, active low. cursor at 0,0, byte counter at header, resolution
//   640 x 480, output empty.
// stall:
//   the output register holds its result while i_m_tready is low; o_s_tready is
//   low only while that register is full and not being drained.
module mouse_packet_cursor_tracker_core #(
    parameter int COORD_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave stream: [7:0] rx_byte
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [mpct_pkg::RX_W-1:0]       i_s_tdata,
    // master stream: [11:0] cursor_x, [23:12] cursor_y
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [2*mpct_pkg::OUT_W-1:0]    o_m_tdata,
    // config write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mpct_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mpct_pkg::RES_W-1:0]      i_cfg_data
);
    import mpct_pkg::*;

    localparam int SUM_W = COORD_BITS + 2;
    localparam int CMP_W = (SUM_W > RES_W) ? SUM_W : RES_W;
    localparam logic [CMP_W-1:0] CMAX = CMP_W'((64'd1 << COORD_BITS) - 64'd1);

    logic [RES_W-1:0]       r_width, r_height;
    t_byte_idx              r_idx, n_idx;
    logic [RX_W-1:0]        r_hdr, n_hdr;
    logic [RX_W-1:0]        r_xbyte, n_xbyte;
    logic [COORD_BITS-1:0]  r_pos_x, n_pos_x;
    logic [COORD_BITS-1:0]  r_pos_y, n_pos_y;
    logic                   r_out_valid, n_out_valid;
    logic [2*OUT_W-1:0]     r_out_data, n_out_data;

    logic                   w_in_xfer;
    logic                   w_out_xfer;
    logic signed [DELTA_W-1:0] w_dx, w_dy;
    logic signed [SUM_W-1:0]   w_sum_x, w_sum_y;
    logic [COORD_BITS-1:0]  w_new_x, w_new_y;

    function automatic logic [COORD_BITS-1:0] clamp_axis(
        input logic signed [SUM_W-1:0] v,
        input logic [RES_W-1:0]        res
    );
        logic [CMP_W-1:0] lim;
        logic [CMP_W-1:0] mag;
        logic [COORD_BITS-1:0] r;
        lim = (res == '0) ? '0 : CMP_W'(res - RES_W'(1));
        if (lim > CMAX) begin
            lim = CMAX;
        end
        mag = CMP_W'(unsigned'(v[SUM_W-2:0]));
        if (v[SUM_W-1]) begin
            r = '0;
        end else if (mag > lim) begin
            r = COORD_BITS'(lim);
        end else begin
            r = COORD_BITS'(mag);
        end
        return r;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign w_in_xfer   = i_s_tvalid && o_s_tready;
    assign w_out_xfer  = r_out_valid && i_m_tready;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    assign w_dx = axis_delta(r_xbyte, r_hdr[HDR_XSIGN], r_hdr[HDR_XOVF]);
    assign w_dy = axis_delta(i_s_tdata, r_hdr[HDR_YSIGN], r_hdr[HDR_YOVF]);

    assign w_sum_x = $signed(SUM_W'(r_pos_x)) + SUM_W'(w_dx);
    assign w_sum_y = $signed(SUM_W'(r_pos_y)) - SUM_W'(w_dy);

    assign w_new_x = clamp_axis(w_sum_x, r_width);
    assign w_new_y = clamp_axis(w_sum_y, r_height);

    always_comb begin
        n_idx       = r_idx;
        n_hdr       = r_hdr;
        n_xbyte     = r_xbyte;
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_out_valid = r_out_valid && !w_out_xfer;
        n_out_data  = r_out_data;
        if (w_in_xfer) begin
            unique case (r_idx)
                BYTE_HDR: begin
                    // hunt for a header with the sync bit set
                    if (i_s_tdata[HDR_SYNC]) begin
                        n_hdr = i_s_tdata;
                        n_idx = BYTE_X;
                    end
                end
                BYTE_X: begin
                    n_xbyte = i_s_tdata;
                    n_idx   = BYTE_Y;
                end
                default: begin
                    n_pos_x     = w_new_x;
                    n_pos_y     = w_new_y;
                    n_idx       = BYTE_HDR;
                    n_out_valid = 1'b1;
                    n_out_data  = {OUT_W'(w_new_y), OUT_W'(w_new_x)};
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= BYTE_HDR;
            r_hdr       <= '0;
            r_xbyte     <= '0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_hdr       <= n_hdr;
            r_xbyte     <= n_xbyte;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                REG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule
